// ----- sv/wsd_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
// Used by wsd_parser, wsd_out_buf and websocket_frame_deframer; no dependencies.
`default_nettype none
package wsd_pkg;

	localparam int unsigned LEN_W = 63;

	localparam logic [7:0] FIN_BIT     = 8'h80;
	localparam logic [7:0] OPCODE_MASK = 8'h0F;
	localparam logic [7:0] LEN7_MASK   = 8'h7F;
	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// parse phase, one-hot
	typedef enum logic [5:0] {
		PH_HDR0  = 6'b000001,
		PH_HDR1  = 6'b000010,
		PH_LEN16 = 6'b000100,
		PH_LEN64 = 6'b001000,
		PH_KEY   = 6'b010000,
		PH_PAY   = 6'b100000
	} phase_t;

	// one result item plus its valid flag
	typedef struct packed {
		logic             vld;
		logic             kind;
		logic [7:0]       data;
		logic             fin;
		logic [3:0]       opcode;
		logic [LEN_W-1:0] length;
		logic             fend;
	} res_t;

endpackage
`default_nettype wire

// ----- sv/wsd_parser.sv -----
// Frame parser: header state machine, length/key capture and payload unmasking.
// Depends on wsd_pkg. Produces at most one result per accepted byte, combinationally.
`default_nettype none
module wsd_parser (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             take,
	input  wire [7:0]       stream_byte,
	output wsd_pkg::res_t   res
);

	wsd_pkg::phase_t                phase_q, phase_d;
	logic                           fin_q, fin_d;
	logic [3:0]                     op_q, op_d;
	logic                           mask_q, mask_d;
	logic [wsd_pkg::LEN_W-1:0]      len_q, len_d;
	logic [2:0]                     cnt_q, cnt_d;
	logic [31:0]                    key_q, key_d;
	logic [wsd_pkg::LEN_W-1:0]      rem_q, rem_d;
	logic [1:0]                     kidx_q, kidx_d;

	logic                           do_finish;
	logic                           after_len;
	logic                           hdr_empty;
	logic [6:0]                     code;
	logic [7:0]                     kb;
	logic                           len_done;

	always_comb begin
		phase_d   = phase_q;
		fin_d     = fin_q;
		op_d      = op_q;
		mask_d    = mask_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		key_d     = key_q;
		rem_d     = rem_q;
		kidx_d    = kidx_q;
		do_finish = 1'b0;
		after_len = 1'b0;
		code      = stream_byte[6:0] & wsd_pkg::LEN7_MASK[6:0];
		kb        = key_q[{~kidx_q, 3'b000} +: 8];
		len_done  = 1'b0;
		res       = '0;

		case (phase_q)
			wsd_pkg::PH_HDR1: begin
				mask_d = stream_byte[7];
				key_d  = '0;
				cnt_d  = '0;
				if (code == wsd_pkg::LEN_CODE_16) begin
					len_d   = '0;
					phase_d = wsd_pkg::PH_LEN16;
				end else if (code == wsd_pkg::LEN_CODE_64) begin
					len_d   = '0;
					phase_d = wsd_pkg::PH_LEN64;
				end else begin
					len_d     = {{(wsd_pkg::LEN_W-7){1'b0}}, code};
					after_len = 1'b1;
				end
			end
			wsd_pkg::PH_LEN16, wsd_pkg::PH_LEN64: begin
				len_d    = {len_q[wsd_pkg::LEN_W-9:0], stream_byte};
				len_done = (phase_q == wsd_pkg::PH_LEN16) ? (cnt_q >= 3'd1)
				                                          : (cnt_q >= 3'd7);
				if (len_done) begin
					after_len = 1'b1;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			wsd_pkg::PH_KEY: begin
				key_d = {key_q[23:0], stream_byte};
				if (cnt_q >= 3'd3) begin
					cnt_d     = '0;
					do_finish = 1'b1;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			wsd_pkg::PH_PAY: begin
				kidx_d     = kidx_q + 2'd1;
				rem_d      = rem_q - {{(wsd_pkg::LEN_W-1){1'b0}}, 1'b1};
				res.vld    = 1'b1;
				res.kind   = wsd_pkg::KIND_PAYLOAD;
				res.data   = stream_byte ^ kb;
				res.fin    = fin_q;
				res.opcode = op_q;
				res.length = len_q;
				res.fend   = (rem_d == '0);
				if (rem_d == '0) begin
					phase_d = wsd_pkg::PH_HDR0;
				end
			end
			default: begin
				fin_d   = stream_byte[7];
				op_d    = stream_byte[3:0] & wsd_pkg::OPCODE_MASK[3:0];
				phase_d = wsd_pkg::PH_HDR1;
			end
		endcase

		// length field done: key follows when masked, else header completes
		if (after_len) begin
			cnt_d = '0;
			if (mask_d) begin
				phase_d = wsd_pkg::PH_KEY;
			end else begin
				do_finish = 1'b1;
			end
		end

		hdr_empty = (len_d == '0);
		if (do_finish) begin
			res.vld    = 1'b1;
			res.kind   = wsd_pkg::KIND_HEADER;
			res.data   = '0;
			res.fin    = fin_d;
			res.opcode = op_d;
			res.length = len_d;
			res.fend   = hdr_empty;
			rem_d      = len_d;
			kidx_d     = '0;
			phase_d    = hdr_empty ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wsd_pkg::PH_HDR0;
			fin_q   <= 1'b0;
			op_q    <= '0;
			mask_q  <= 1'b0;
			len_q   <= '0;
			cnt_q   <= '0;
			key_q   <= '0;
			rem_q   <= '0;
			kidx_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			fin_q   <= fin_d;
			op_q    <= op_d;
			mask_q  <= mask_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			key_q   <= key_d;
			rem_q   <= rem_d;
			kidx_q  <= kidx_d;
		end
	end

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("parse phase is not one-hot");

	// every payload byte yields a payload item
	a_pay_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && phase_q == wsd_pkg::PH_PAY) |-> (res.vld && res.kind == wsd_pkg::KIND_PAYLOAD))
		else $error("payload byte produced no payload item");

	// a header item never comes from the first header byte
	a_hdr0_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take && phase_q == wsd_pkg::PH_HDR0) |-> !res.vld)
		else $error("first header byte produced an item");

endmodule
`default_nettype wire

// ----- sv/wsd_out_buf.sv -----
// Result register with a skid entry, so input keeps flowing while a result waits.
// Depends on wsd_pkg for the result struct.
`default_nettype none
module wsd_out_buf (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wire wsd_pkg::res_t   push_res,
	output logic                 can_push,
	output logic                 out_valid,
	input  wire                  out_ready,
	output wsd_pkg::res_t        out_res
);

	logic            out_vld_q;
	logic            skid_vld_q;
	wsd_pkg::res_t   out_q;
	wsd_pkg::res_t   skid_q;
	logic            pop;

	assign can_push  = !skid_vld_q;
	assign out_valid = out_vld_q;
	assign out_res   = out_q;
	assign pop       = out_vld_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (skid_vld_q) begin
				if (pop) begin
					skid_vld_q <= 1'b0;
				end
			end else if (!out_vld_q || pop) begin
				out_vld_q <= push;
			end else if (push) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (!out_vld_q || pop) begin
			if (push) begin
				out_q <= push_res;
			end
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry held with empty output register");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && out_ready) |=> (!skid_vld_q && out_vld_q))
		else $error("skid entry not moved forward on pop");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_vld_q && !out_ready) |=> skid_vld_q)
		else $error("item pushed during stall was not kept");

endmodule
`default_nettype wire

// ----- sv/websocket_frame_deframer.sv -----
// Top level of the WebSocket frame deframer; instantiates wsd_parser and wsd_out_buf.
// Depends on wsd_pkg.
//
// Takes one received byte per cycle while in_ready is high and yields one item
// per cycle at most: a header summary once a frame header is complete (flagged
// frame_end when the length is zero), then one unmasked payload byte per input
// byte, the last flagged frame_end. Header bytes before the last give no item.
// Every byte is parsed combinationally and its result registered. A two-entry
// output buffer (result register plus skid entry) lets input continue for one
// more item while the output stalls; in_ready drops only when both entries
// are full.
`default_nettype none
module websocket_frame_deframer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  stream_byte,
	output logic        out_valid,
	input  wire         out_ready,
	output logic        item_kind,
	output logic [7:0]  payload_byte,
	output logic        final_fragment,
	output logic [3:0]  frame_opcode,
	output logic [62:0] payload_length,
	output logic        frame_end
);

	logic            take;
	logic            can_push;
	wsd_pkg::res_t   res;
	wsd_pkg::res_t   out_res;

	assign in_ready = can_push;
	assign take     = in_valid && can_push;

	wsd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.stream_byte (stream_byte),
		.res         (res)
	);

	wsd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && res.vld),
		.push_res  (res),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign item_kind      = out_res.kind;
	assign payload_byte   = out_res.data;
	assign final_fragment = out_res.fin;
	assign frame_opcode   = out_res.opcode;
	assign payload_length = out_res.length;
	assign frame_end      = out_res.fend;

endmodule
`default_nettype wire
